// File: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define FPA_NEVER(lbl, cond, msg) \
	`FPA_ASSERT(lbl, !(cond), msg)

`endif

// File: src/fpa_pkg.sv
`default_nettype none
package fpa_pkg;
	localparam int unsigned XW = 32;
	localparam int unsigned DW = 64;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_GT  = 4'd4;
	localparam logic [3:0] OP_LT  = 4'd5;
	localparam logic [3:0] OP_EQ  = 4'd6;
	localparam logic [3:0] OP_GE  = 4'd7;
	localparam logic [3:0] OP_LE  = 4'd8;
	localparam logic [3:0] OP_NE  = 4'd9;
	localparam logic [3:0] OP_MIN = 4'd10;
	localparam logic [3:0] OP_MAX = 4'd11;
	localparam logic [3:0] OP_INC = 4'd12;
	localparam logic [3:0] OP_DEC = 4'd13;
	localparam logic [3:0] OP_I2F = 4'd14;
	localparam logic [3:0] OP_F2I = 4'd15;

	// One item in flight; divider fields are worked on cell by cell.
	typedef struct packed {
		logic [3:0]    op;
		logic [XW-1:0] res;
		logic          flag;
		logic          dz;
		logic          neg;
		logic [DW-1:0] prod;
		logic [XW:0]   rem;
		logic [DW-1:0] dvd;
		logic [XW-1:0] dsr;
		logic [XW-1:0] quo;
	} tok_t;

	// Keep the low w bits and sign-extend them to 32.
	function automatic logic [XW-1:0] sext_w(input logic [XW-1:0] x, input int unsigned w);
		logic [XW-1:0] t;
		t = x << (XW - w);
		return $unsigned($signed(t) >>> (XW - w));
	endfunction
endpackage
`default_nettype wire

// File: src/fpa_if.sv
`default_nettype none
interface fpa_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	modport source (output valid, func, operand_a, operand_b, input ready);
	modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        flag;
	logic        div_by_zero;
	modport source (output valid, result, flag, div_by_zero, input ready);
	modport sink   (input valid, result, flag, div_by_zero, output ready);
endinterface
`default_nettype wire

// File: src/fixed_point_alu_unit.sv
// Path: front register, WORD_WIDTH + FRACTION_BITS divider cells, output register.
// Throughput: one beat per cycle, every operation, unless the output stalls; the divider
// is a row of WORD_WIDTH + FRACTION_BITS restoring cells, one quotient bit per cell.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data regs are not reset.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu_unit #(
	parameter int unsigned WORD_WIDTH    = 32,
	parameter int unsigned FRACTION_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fpa_in_if.sink    in_ch,
	fpa_out_if.source out_ch
);
	import fpa_pkg::*;

	// Dividend |a| * 2^F has this many bits, one cell per bit.
	localparam int unsigned NCELL = WORD_WIDTH + FRACTION_BITS;

	// Link i feeds cell i; link NCELL feeds the output stage.
	tok_t tok   [0:NCELL];
	logic vld   [0:NCELL];
	logic rdy   [0:NCELL];

	// Front stage: operand wrap, simple ops, multiplier, divider setup.
	fpa_front #(
		.WORD_WIDTH    (WORD_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0]),
		.dn_tok   (tok[0])
	);

	// Divider chain. Every beat walks the whole row so order is kept;
	// each cell stalls only when its neighbor is full and stalled.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fpa_div_cell #(
			.DVD_BITS (NCELL)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_tok   (tok[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_tok   (tok[i+1])
		);
	end

	// Output stage: mul truncation, quotient sign, result register.
	fpa_back #(
		.WORD_WIDTH    (WORD_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld[NCELL]),
		.up_ready (rdy[NCELL]),
		.up_tok   (tok[NCELL]),
		.out_ch   (out_ch)
	);

	// Divide by zero yields a zero result and no flag.
	`FPA_ASSERT(a_dz_zero, out_ch.valid && out_ch.div_by_zero |-> out_ch.result == '0 && !out_ch.flag, "div by zero beat carries data")
	// A true comparison carries a zero result.
	`FPA_ASSERT(a_flag_zero, out_ch.valid && out_ch.flag |-> out_ch.result == '0, "flag with nonzero result")
	// Input backs up only when the whole chain is full behind a stalled output.
	`FPA_NEVER(a_stall_src, !in_ch.ready && !(out_ch.valid && !out_ch.ready), "input stalled without output stall")
endmodule
`default_nettype wire

// File: src/fpa_front.sv
`default_nettype none
module fpa_front #(
	parameter int unsigned WORD_WIDTH    = 32,
	parameter int unsigned FRACTION_BITS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fpa_in_if.sink      in_ch,
	output logic        dn_valid,
	input  wire logic   dn_ready,
	output fpa_pkg::tok_t dn_tok
);
	import fpa_pkg::*;

	localparam logic [XW-1:0] BIAS = XW'((64'd1 << FRACTION_BITS) - 64'd1);

	logic signed [XW-1:0] a, b;
	logic [XW-1:0] mag_a, mag_b, f2i;
	logic [XW-1:0] r;
	logic          fl;
	tok_t          nxt, tok_q;
	logic          v_q;

	always_comb begin
		a     = $signed(sext_w(in_ch.operand_a, WORD_WIDTH));
		b     = $signed(sext_w(in_ch.operand_b, WORD_WIDTH));
		mag_a = a[XW-1] ? XW'(-a) : XW'(a);
		mag_b = b[XW-1] ? XW'(-b) : XW'(b);
		f2i   = $unsigned((a + $signed(a[XW-1] ? BIAS : '0)) >>> FRACTION_BITS);
		r     = '0;
		fl    = 1'b0;
		unique case (in_ch.func)
			OP_ADD: r = XW'(a + b);
			OP_SUB: r = XW'(a - b);
			OP_MUL: r = '0;
			OP_DIV: r = '0;
			OP_GT:  fl = a > b;
			OP_LT:  fl = a < b;
			OP_EQ:  fl = a == b;
			OP_GE:  fl = a >= b;
			OP_LE:  fl = a <= b;
			OP_NE:  fl = a != b;
			OP_MIN: r = (a > b) ? b : a;
			OP_MAX: r = (a > b) ? a : b;
			OP_INC: r = XW'(a + 1);
			OP_DEC: r = XW'(a - 1);
			OP_I2F: r = XW'(a) << FRACTION_BITS;
			OP_F2I: r = f2i;
		endcase
		nxt.op   = in_ch.func;
		nxt.res  = sext_w(r, WORD_WIDTH);
		nxt.flag = fl;
		nxt.dz   = (in_ch.func == OP_DIV) && (b == '0);
		nxt.neg  = a[XW-1] ^ b[XW-1];
		nxt.prod = DW'(a * b);
		nxt.rem  = '0;
		nxt.dvd  = {{(DW-XW){1'b0}}, mag_a} << FRACTION_BITS;
		nxt.dsr  = mag_b;
		nxt.quo  = '0;
	end

	assign in_ch.ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ch.ready) begin
			v_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			tok_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_tok   = tok_q;
endmodule
`default_nettype wire

// File: src/fpa_div_cell.sv
`default_nettype none
module fpa_div_cell #(
	parameter int unsigned DVD_BITS = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire fpa_pkg::tok_t up_tok,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output fpa_pkg::tok_t      dn_tok
);
	import fpa_pkg::*;

	logic [XW:0] trial, dsr_x, diff;
	logic        ge;
	tok_t        nxt, tok_q;
	logic        v_q;

	// One restoring step: bring in the next dividend bit, try the subtract.
	always_comb begin
		trial    = {up_tok.rem[XW-1:0], up_tok.dvd[DVD_BITS-1]};
		dsr_x    = {1'b0, up_tok.dsr};
		diff     = trial - dsr_x;
		ge       = trial >= dsr_x;
		nxt      = up_tok;
		nxt.rem  = ge ? diff : trial;
		nxt.dvd  = up_tok.dvd << 1;
		nxt.quo  = {up_tok.quo[XW-2:0], ge};
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			tok_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_tok   = tok_q;
endmodule
`default_nettype wire

// File: src/fpa_back.sv
`default_nettype none
module fpa_back #(
	parameter int unsigned WORD_WIDTH    = 32,
	parameter int unsigned FRACTION_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire fpa_pkg::tok_t up_tok,
	fpa_out_if.source          out_ch
);
	import fpa_pkg::*;

	localparam logic [DW-1:0] BIAS = DW'((64'd1 << FRACTION_BITS) - 64'd1);

	logic [DW-1:0] pb, ps;
	logic [XW-1:0] qv, r;
	logic [XW-1:0] res_q;
	logic          flag_q, dz_q, v_q;

	// Product truncates toward zero; quotient takes its sign back.
	always_comb begin
		pb = up_tok.prod + (up_tok.prod[DW-1] ? BIAS : '0);
		ps = $unsigned($signed(pb) >>> FRACTION_BITS);
		qv = up_tok.neg ? XW'(-up_tok.quo) : up_tok.quo;
		case (up_tok.op)
			OP_MUL:  r = sext_w(ps[XW-1:0], WORD_WIDTH);
			OP_DIV:  r = up_tok.dz ? '0 : sext_w(qv, WORD_WIDTH);
			default: r = up_tok.res;
		endcase
	end

	assign up_ready = !v_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_q  <= r;
			flag_q <= up_tok.flag;
			dz_q   <= up_tok.dz;
		end
	end

	assign out_ch.valid       = v_q;
	assign out_ch.result      = res_q;
	assign out_ch.flag        = flag_q;
	assign out_ch.div_by_zero = dz_q;
endmodule
`default_nettype wire

// File: dv/fixed_point_alu_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_unit_tb;
	import fpa_pkg::*;

	localparam int FRAC      = 8;
	localparam int N_RANDOM  = 1400;
	localparam int LONG_HOLD = 300;
	// no beat for this long on either channel means the block is stuck
	localparam int WATCHDOG  = 5000;

	typedef struct packed {
		logic [31:0] result;
		logic        flag;
		logic        dz;
	} alu_res_t;

	typedef struct {
		logic [3:0]  func;
		logic [31:0] a;
		logic [31:0] b;
		bit          typed;	// expected value given in the table
		alu_res_t    res;
	} op_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpa_in_if  in_ch();
	fpa_out_if out_ch();

	fixed_point_alu_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	op_item_t offered_q[$];       // items in the order the sender presents them
	alu_res_t pending_results[$]; // results owed by the block, oldest first
	int       errors = 0;
	int       idle_cycles = 0;
	bit       hold_req = 1'b0;    // ask the receiver for one long hold
	bit       quiet = 1'b0;       // stretch with no idling on either side

	// Predictor. WORD_WIDTH is 32 here so operands are used whole.
	function automatic alu_res_t fixed_point_result(logic [3:0] op, logic [31:0] ra,
			logic [31:0] rb);
		longint   a, b, r;
		alu_res_t o;
		a = longint'($signed(ra));
		b = longint'($signed(rb));
		r = 0;
		o = '0;
		case (op)
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_MUL: r = (a * b) / (longint'(1) << FRAC); // SV '/' truncates toward zero
			OP_DIV: begin
				if (b == 0)
					o.dz = 1'b1;
				else
					r = (a * (longint'(1) << FRAC)) / b;
			end
			OP_GT:  o.flag = a > b;
			OP_LT:  o.flag = a < b;
			OP_EQ:  o.flag = a == b;
			OP_GE:  o.flag = a >= b;
			OP_LE:  o.flag = a <= b;
			OP_NE:  o.flag = a != b;
			OP_MIN: r = (a > b) ? b : a;
			OP_MAX: r = (a > b) ? a : b;
			OP_INC: r = a + 1;
			OP_DEC: r = a - 1;
			OP_I2F: r = a <<< FRAC;
			default: r = a / (longint'(1) << FRAC);
		endcase
		o.result = r[31:0];
		return o;
	endfunction

	function automatic op_item_t mk(logic [3:0] f, logic [31:0] a, logic [31:0] b,
			bit typed = 1'b0, logic [31:0] r = '0, logic fl = 1'b0, logic dz = 1'b0);
		op_item_t it;
		it.func = f;
		it.a = a;
		it.b = b;
		it.typed = typed;
		it.res = '{result: r, flag: fl, dz: dz};
		return it;
	endfunction

	// Operand mix: corners often, full random words otherwise.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0100;	// 1.0
			5: return 32'($signed($urandom_range(0, 4096)) - 2048);
			default: return $urandom;
		endcase
	endfunction

	// Monitor: both channels sampled at the edge, before the driver's NBAs land.
	always @(posedge clk) begin
		op_item_t it;
		alu_res_t got, want;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_ch.valid && in_ch.ready) begin
				it = offered_q.pop_front();
				pending_results.push_back(it.typed ? it.res :
					fixed_point_result(it.func, it.a, it.b));
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{result: out_ch.result, flag: out_ch.flag, dz: out_ch.div_by_zero};
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat %h/%b/%b", $realtime,
						got.result, got.flag, got.dz);
				end else begin
					want = pending_results.pop_front();
					if (got.result !== want.result) begin
						errors++;
						$display("%0t: result exp %h got %h", $realtime, want.result, got.result);
					end
					if (got.flag !== want.flag) begin
						errors++;
						$display("%0t: flag exp %b got %b", $realtime, want.flag, got.flag);
					end
					if (got.dz !== want.dz) begin
						errors++;
						$display("%0t: div_by_zero exp %b got %b", $realtime, want.dz, got.dz);
					end
				end
			end
		end
	end

	// Watchdog on beats; a timeout is a failure.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold on request, none while quiet.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				out_ch.ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						out_ch.ready <= 1'b0;
						repeat ($urandom_range(10, 40)) @(posedge clk);
					end
					1, 2, 3, 4: out_ch.ready <= 1'b0;
					default: out_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Present one beat and hold it until taken; valid stays up if no gap follows.
	task automatic offer_op(op_item_t it, int gap);
		offered_q.push_back(it);
		in_ch.valid     <= 1'b1;
		in_ch.func      <= it.func;
		in_ch.operand_a <= it.a;
		in_ch.operand_b <= it.b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int sender_gap();
		int g;
		if (quiet || hold_req)
			return 0;
		g = $urandom_range(0, 99);
		if (g < 65)
			return 0;
		if (g < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	op_item_t directed[$];

	initial begin
		op_item_t it;
		in_ch.valid     = 1'b0;
		in_ch.func      = '0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;

		// Directed table: typed rows for obvious outcomes, the rest go to the predictor.
		directed = '{
			mk(OP_ADD, 32'h7fff_ffff, 32'h1,         1, 32'h8000_0000),	// add wraps
			mk(OP_SUB, 32'h8000_0000, 32'h1,         1, 32'h7fff_ffff),	// sub wraps
			mk(OP_MUL, 32'h0000_0100, 32'h0000_0100, 1, 32'h0000_0100),	// 1.0 * 1.0
			mk(OP_MUL, 32'h8000_0000, 32'h8000_0000),
			mk(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 1, 32'h0),		// truncates toward zero
			mk(OP_DIV, 32'h0000_0100, 32'h0,         1, 32'h0, 1'b0, 1'b1),	// divide by zero
			mk(OP_DIV, 32'h8000_0000, 32'h0,         1, 32'h0, 1'b0, 1'b1),
			mk(OP_DIV, 32'h8000_0000, 32'hffff_ffff),
			mk(OP_DIV, 32'h7fff_ffff, 32'h8000_0000),
			mk(OP_DIV, 32'hffff_fd00, 32'h0000_0200),
			mk(OP_GT,  32'h7fff_ffff, 32'h8000_0000, 1, 32'h0, 1'b1),
			mk(OP_LT,  32'h7fff_ffff, 32'h8000_0000, 1, 32'h0, 1'b0),
			mk(OP_EQ,  32'h8000_0000, 32'h8000_0000, 1, 32'h0, 1'b1),
			mk(OP_GE,  32'hffff_ffff, 32'hffff_ffff, 1, 32'h0, 1'b1),
			mk(OP_LE,  32'h0,         32'hffff_ffff, 1, 32'h0, 1'b0),
			mk(OP_NE,  32'h0,         32'h0,         1, 32'h0, 1'b0),
			mk(OP_MIN, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h8000_0000),
			mk(OP_MAX, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff),
			mk(OP_INC, 32'h7fff_ffff, 32'hffff_ffff, 1, 32'h8000_0000),
			mk(OP_DEC, 32'h8000_0000, 32'hffff_ffff, 1, 32'h7fff_ffff),
			mk(OP_I2F, 32'h0000_0001, 32'h0,         1, 32'h0000_0100),
			mk(OP_I2F, 32'h8000_0001, 32'h0,         1, 32'h0000_0100),	// shifted out
			mk(OP_F2I, 32'hffff_ff00, 32'h0,         1, 32'hffff_ffff),
			mk(OP_F2I, 32'hffff_ffff, 32'h0,         1, 32'h0),		// -tiny -> 0
			mk(OP_F2I, 32'h8000_0000, 32'h0,         1, 32'hff80_0000)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_op(directed[i], sender_gap());

		for (int n = 0; n < N_RANDOM; n++) begin
			// alternate stretches with and without idling
			if (n % 200 == 0)
				quiet = (n % 400 == 200);
			// long receiver hold while the sender keeps pushing: fills the pipe
			if (n == 600)
				hold_req = 1'b1;
			// sender drains everything before going on
			if (n == 1000) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0 || offered_q.size() != 0)
					@(posedge clk);
			end
			it = mk(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
			offer_op(it, sender_gap());
		end
		in_ch.valid <= 1'b0;

		// let the monitor log the last accepted beat before checking the backlog
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
